// File: rtl/core/pcx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants for the PCX run-length scanline decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam int POS_W  = 18;
    localparam int ROW_W  = 17;
    localparam int IDX_W  = 16;
    localparam int CNT_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

    localparam logic [POS_W-1:0] SCAN_RESET = 18'd320;
    localparam logic [POS_W-1:0] CAP_RESET  = 18'd320;
    localparam logic [ROW_W-1:0] ROWS_RESET = 17'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_STATUS
    } t_state;

    // results of one evaluation of the step unit
    typedef struct packed {
        logic             overflow;
        logic             row_end;
        logic             last_row;
        logic             wrap_fin;
        logic             row_over;
        logic [POS_W-1:0] pos_inc;
        logic [ROW_W-1:0] row_inc;
    } t_step_res;

endpackage

// File: rtl/core/pcx_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_step_unit
// Position and row arithmetic used by the sequencer once per result: the
// position and row increments and the capacity, scanline and row compares.
// ----------------------------------------------------------------------------
module pcx_step_unit
    import pcx_pkg::*;
(
    input  logic [POS_W-1:0] i_pos,
    input  logic [ROW_W-1:0] i_row,
    input  logic [POS_W-1:0] i_scan,
    input  logic [POS_W-1:0] i_cap,
    input  logic [ROW_W-1:0] i_rows,
    output t_step_res        o_res
);

    logic [POS_W:0] w_pos_inc;
    logic [ROW_W:0] w_row_inc;

    assign w_pos_inc = {1'b0, i_pos} + {{POS_W{1'b0}}, 1'b1};
    assign w_row_inc = {1'b0, i_row} + {{ROW_W{1'b0}}, 1'b1};

    always_comb begin
        o_res.overflow = (i_pos >= i_cap);
        o_res.row_end  = (w_pos_inc >= {1'b0, i_scan});
        // unwrapped compare for the image-done flag, wrapped for the finish
        o_res.last_row = (w_row_inc >= {1'b0, i_rows});
        o_res.wrap_fin = (w_row_inc[ROW_W-1:0] >= i_rows);
        o_res.row_over = (i_row >= i_rows);
        o_res.pos_inc  = w_pos_inc[POS_W-1:0];
        o_res.row_inc  = w_row_inc[ROW_W-1:0];
    end

endmodule

// File: rtl/core/pcx_rle_scanline_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder
// PCX run-length decoder: expands compressed body bytes into row-tagged bytes.
// ----------------------------------------------------------------------------
// A byte is taken while the sequencer is idle. A count byte then frees the
// input again at once (after an early-end status word if it ends the input);
// a literal or the data byte of a run of n occupies the block while the
// sequencer issues its n words, one word per cycle while the output register
// is not held by a stall, through the shared position/row step unit into the
// output register. A run that hits the line capacity stops at its status
// word. A zero-length run or an ignored byte also frees the input at once
// (after a status word for a zero-length run with an early end). The input is
// stalled while a run expands; the next byte is taken while the last word of
// a run still waits downstream.
module pcx_rle_scanline_decoder
    import pcx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_raw_byte,
    input  logic                 i_end_of_input,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_has_data,
    output logic [BYTE_W-1:0]    o_pixel_byte,
    output logic [POS_W-1:0]     o_byte_position,
    output logic [IDX_W-1:0]     o_row_index,
    output logic                 o_row_done,
    output logic                 o_image_done,
    output logic                 o_last_of_run,
    output logic                 o_size_issue
);

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_scan, r_cap;
    logic [ROW_W-1:0]  r_rows;
    logic [CNT_W-1:0]  r_pend_cnt, n_pend_cnt;
    logic              r_run_pend, n_run_pend;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_fin, n_fin;
    logic              r_issue, n_issue;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_eoi, n_eoi;

    logic              r_out_valid, n_out_valid;
    logic              r_out_has, r_out_rd, r_out_id, r_out_last, r_out_iss;
    logic [BYTE_W-1:0] r_out_px;
    logic [POS_W-1:0]  r_out_pos;
    logic [IDX_W-1:0]  r_out_row;

    logic              w_emit, w_slot_free, w_accept, w_fin_after;
    logic              e_has, e_rd, e_id, e_last, e_iss;
    logic [BYTE_W-1:0] e_px;
    t_step_res         w_step;

    pcx_step_unit u_step (
        .i_pos  (r_pos),
        .i_row  (r_row),
        .i_scan (r_scan),
        .i_cap  (r_cap),
        .i_rows (r_rows),
        .o_res  (w_step)
    );

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_pend_cnt  = r_pend_cnt;
        n_run_pend  = r_run_pend;
        n_pos       = r_pos;
        n_row       = r_row;
        n_fin       = r_fin;
        n_issue     = r_issue;
        n_remain    = r_remain;
        n_data      = r_data;
        n_eoi       = r_eoi;
        w_emit      = 1'b0;
        w_fin_after = 1'b0;
        e_has       = 1'b0;
        e_px        = '0;
        e_rd        = 1'b0;
        e_id        = 1'b0;
        e_last      = 1'b0;
        e_iss       = r_issue;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_fin || w_step.row_over) begin
                        // drop the byte once the image is complete
                        n_fin = 1'b1;
                    end else if (r_run_pend) begin
                        n_run_pend = 1'b0;
                        if (r_pend_cnt == '0) begin
                            if (i_end_of_input) begin
                                n_issue = 1'b1;
                                n_state = ST_STATUS;
                            end
                        end else begin
                            n_remain = r_pend_cnt;
                            n_data   = i_raw_byte;
                            n_eoi    = i_end_of_input;
                            n_state  = ST_RUN;
                        end
                    end else if ((i_raw_byte & RUN_MARK) == RUN_MARK) begin
                        n_pend_cnt = CNT_W'(i_raw_byte & RUN_MASK);
                        n_run_pend = 1'b1;
                        if (i_end_of_input) begin
                            n_issue = 1'b1;
                            n_state = ST_STATUS;
                        end
                    end else begin
                        n_remain = CNT_W'(1);
                        n_data   = i_raw_byte;
                        n_eoi    = i_end_of_input;
                        n_state  = ST_RUN;
                    end
                end
            end
            ST_STATUS: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    e_last  = 1'b1;
                    e_iss   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (w_slot_free) begin
                    w_emit = 1'b1;
                    if (w_step.overflow) begin
                        // drop the write, close the row and discard the run
                        e_rd    = 1'b1;
                        e_id    = w_step.last_row;
                        e_last  = 1'b1;
                        e_iss   = 1'b1;
                        n_issue = 1'b1;
                        n_pos   = '0;
                        n_row   = w_step.row_inc;
                        n_fin   = w_step.wrap_fin;
                        n_state = ST_IDLE;
                    end else begin
                        e_has    = 1'b1;
                        e_px     = r_data;
                        n_pos    = w_step.pos_inc;
                        n_remain = r_remain - CNT_W'(1);
                        if (r_remain == CNT_W'(1)) begin
                            e_last  = 1'b1;
                            n_state = ST_IDLE;
                            if (w_step.row_end) begin
                                e_rd        = 1'b1;
                                e_id        = w_step.last_row;
                                n_pos       = '0;
                                n_row       = w_step.row_inc;
                                n_fin       = w_step.wrap_fin;
                                w_fin_after = w_step.wrap_fin;
                            end
                            if (r_eoi && !w_fin_after) begin
                                n_issue = 1'b1;
                                e_iss   = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend_cnt  <= '0;
            r_run_pend  <= 1'b0;
            r_pos       <= '0;
            r_row       <= '0;
            r_fin       <= 1'b0;
            r_issue     <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_cnt  <= n_pend_cnt;
            r_run_pend  <= n_run_pend;
            r_pos       <= n_pos;
            r_row       <= n_row;
            r_fin       <= n_fin;
            r_issue     <= n_issue;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
            r_cap  <= CAP_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCAN_BYTES:    r_scan <= i_cfg_data;
                CFG_LINE_CAPACITY: r_cap  <= i_cfg_data;
                CFG_ROW_COUNT:     r_rows <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload of the run and of the output word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_eoi  <= n_eoi;
        if (w_emit) begin
            r_out_has  <= e_has;
            r_out_px   <= e_px;
            r_out_pos  <= r_pos;
            r_out_row  <= r_row[IDX_W-1:0];
            r_out_rd   <= e_rd;
            r_out_id   <= e_id;
            r_out_last <= e_last;
            r_out_iss  <= e_iss;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_has_data      = r_out_has;
    assign o_pixel_byte    = r_out_px;
    assign o_byte_position = r_out_pos;
    assign o_row_index     = r_out_row;
    assign o_row_done      = r_out_rd;
    assign o_image_done    = r_out_id;
    assign o_last_of_run   = r_out_last;
    assign o_size_issue    = r_out_iss;

    a_status_flags_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data |-> o_size_issue && o_last_of_run)
        else $error("status word without issue flag or last marker");

    a_image_done_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_done |-> o_row_done)
        else $error("image done without row done");

    a_row_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_done |-> o_last_of_run)
        else $error("row ended before the last word of a byte");

    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state != ST_IDLE))
        else $error("word issued from idle sequencer");

    a_issue_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_issue) |-> r_issue)
        else $error("issue flag cleared");

endmodule

// File: tb/pcx_rle_scanline_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_test
// Self-checking bench for the PCX run-length scanline decoder. A row tracker
// mirrors the decoder's run, row and issue state; it expands each accepted
// byte into the words it must cause, and every word leaving the block is
// compared field by field with the oldest one still owed. Directed bytes
// come first, then random count/data pairs, literals and stray bytes under
// several register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_test
    import pcx_pkg::*;
();

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef struct packed {
        logic              has_data;
        logic [BYTE_W-1:0] pixel;
        logic [POS_W-1:0]  position;
        logic [IDX_W-1:0]  row;
        logic              row_done;
        logic              image_done;
        logic              last_of_run;
        logic              size_issue;
    } t_decoded_word;

    class pcx_row_scoreboard;
        logic [POS_W-1:0] scan_bytes;
        logic [POS_W-1:0] line_cap;
        logic [ROW_W-1:0] row_limit;
        logic [CNT_W-1:0] run_len;
        logic             run_armed;
        logic [POS_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             finished;
        logic             issue;
        t_decoded_word    expected_words[$];
        int               errors;

        function new();
            scan_bytes = SCAN_RESET;
            line_cap   = CAP_RESET;
            row_limit  = ROWS_RESET;
            run_len    = '0;
            run_armed  = 1'b0;
            col        = '0;
            row        = '0;
            finished   = 1'b0;
            issue      = 1'b0;
            errors     = 0;
        endfunction

        function void set_limits(int scan, int cap, int rows);
            scan_bytes = POS_W'(scan);
            line_cap   = POS_W'(cap);
            row_limit  = ROW_W'(rows);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int row_now();
            return int'(row);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        function void advance_row();
            col = '0;
            row = row + 1'b1;
            if (row >= row_limit)
                finished = 1'b1;
        endfunction

        function t_decoded_word make_word(logic hd, logic [BYTE_W-1:0] px, logic rd,
                                          logic idone);
            return {hd, px, col, row[IDX_W-1:0], rd, idone, 1'b0, issue};
        endfunction

        // expand one accepted byte into the words it owes
        function void note_byte(logic [BYTE_W-1:0] raw, logic eoi);
            t_decoded_word words[64];
            logic [CNT_W-1:0] len;
            logic [BYTE_W-1:0] value;
            logic emit;
            logic cut;
            logic last_row;
            int n;
            int i;
            n = 0;
            emit = 1'b0;
            cut = 1'b0;
            len = '0;
            value = '0;
            if (finished || row >= row_limit) begin
                finished = 1'b1;
                return;
            end
            if (run_armed) begin
                len = run_len;
                value = raw;
                run_armed = 1'b0;
                emit = 1'b1;
            end else if ((raw & RUN_MARK) == RUN_MARK) begin
                run_len = CNT_W'(raw & RUN_MASK);
                run_armed = 1'b1;
            end else begin
                len = CNT_W'(1);
                value = raw;
                emit = 1'b1;
            end
            if (emit) begin
                for (i = 0; i < int'(len); i++) begin
                    if (col >= line_cap) begin
                        // drop the write, flag it and close the row
                        last_row = (int'(row) + 1 >= int'(row_limit));
                        issue = 1'b1;
                        words[n] = make_word(1'b0, '0, 1'b1, last_row);
                        n++;
                        advance_row();
                        cut = 1'b1;
                        break;
                    end
                    words[n] = make_word(1'b1, value, 1'b0, 1'b0);
                    n++;
                    col = col + 1'b1;
                end
                if (!cut && n > 0 && col >= scan_bytes) begin
                    words[n-1].row_done = 1'b1;
                    if (int'(row) + 1 >= int'(row_limit))
                        words[n-1].image_done = 1'b1;
                    advance_row();
                end
            end
            if (eoi && !finished) begin
                issue = 1'b1;
                if (n == 0) begin
                    words[n] = make_word(1'b0, '0, 1'b0, 1'b0);
                    n++;
                end else begin
                    words[n-1].size_issue = 1'b1;
                end
            end
            if (n > 0)
                words[n-1].last_of_run = 1'b1;
            for (i = 0; i < n; i++)
                expected_words.push_back(words[i]);
        endfunction

        task compare(string name, int got, int want);
            if (got != want)
                report($sformatf("%s: got %0d, want %0d", name, got, want));
        endtask

        task check_word(t_decoded_word got);
            t_decoded_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word at row %0d position %0d",
                                 got.row, got.position));
                return;
            end
            want = expected_words.pop_front();
            compare("has_data", got.has_data, want.has_data);
            compare("pixel_byte", got.pixel, want.pixel);
            compare("byte_position", got.position, want.position);
            compare("row_index", got.row, want.row);
            compare("row_done", got.row_done, want.row_done);
            compare("image_done", got.image_done, want.image_done);
            compare("last_of_run", got.last_of_run, want.last_of_run);
            compare("size_issue", got.size_issue, want.size_issue);
        endtask

        task close_out();
            if (expected_words.size() != 0)
                report($sformatf("%0d words never arrived", expected_words.size()));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_raw_byte;
    logic                 i_end_of_input;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_has_data;
    logic [BYTE_W-1:0]    o_pixel_byte;
    logic [POS_W-1:0]     o_byte_position;
    logic [IDX_W-1:0]     o_row_index;
    logic                 o_row_done;
    logic                 o_image_done;
    logic                 o_last_of_run;
    logic                 o_size_issue;

    pcx_row_scoreboard board;
    int send_gap_max = 0;
    int recv_gap_max = 0;
    bit hold_output = 1'b0;

    pcx_rle_scanline_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_byte      (i_raw_byte),
        .i_end_of_input  (i_end_of_input),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_has_data      (o_has_data),
        .o_pixel_byte    (o_pixel_byte),
        .o_byte_position (o_byte_position),
        .o_row_index     (o_row_index),
        .o_row_done      (o_row_done),
        .o_image_done    (o_image_done),
        .o_last_of_run   (o_last_of_run),
        .o_size_issue    (o_size_issue)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // offer one byte and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] raw, input logic eoi);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_raw_byte     <= raw;
        i_end_of_input <= eoi;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        board.note_byte(raw, eoi);
    endtask

    function automatic logic random_eoi();
        return ($urandom_range(0, 24) == 0);
    endfunction

    task automatic send_random(input int count);
        int sent;
        int pick;
        logic [CNT_W-1:0] len;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_byte(BYTE_W'($urandom_range(0, 8'hBF)), random_eoi());
                sent++;
            end else if (pick < 90) begin
                if ($urandom_range(0, 9) == 0)
                    len = CNT_W'($urandom_range(0, 63));
                else
                    len = CNT_W'($urandom_range(0, 8));
                send_byte(RUN_MARK | {2'b00, len}, random_eoi());
                send_byte(BYTE_W'($urandom_range(0, 255)), random_eoi());
                sent += 2;
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)), random_eoi());
                sent++;
            end
        end
    endtask

    // drop valid and wait out every owed word, then let the block go quiet
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int scan, input int cap, input int rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCAN_BYTES;
        i_cfg_data  <= CFG_W'(scan);
        @(posedge i_clk);
        i_cfg_index <= CFG_LINE_CAPACITY;
        i_cfg_data  <= CFG_W'(cap);
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data  <= CFG_W'(rows);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_limits(scan, cap, rows);
    endtask

    initial begin : receiver
        int wait_cycles;
        i_out_stall <= 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = $urandom_range(0, recv_gap_max);
            if (hold_output) begin
                wait_cycles = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            board.check_word({o_has_data, o_pixel_byte, o_byte_position, o_row_index,
                              o_row_done, o_image_done, o_last_of_run, o_size_issue});
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int rows;
        board = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_SCAN_BYTES;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_raw_byte     <= '0;
        i_end_of_input <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bytes under the reset settings, all within row 0
        send_gap_max = 10;
        recv_gap_max = 10;
        send_byte(8'h00, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC0, 1'b0);       // zero-length run
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b0);       // longest run
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC1, 1'b0);       // count of one; its data byte looks like a count
        send_byte(8'hC0, 1'b0);
        send_byte(8'hC4, 1'b0);
        send_byte(8'hC7, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h55, 1'b1);       // early end on the data of a run
        send_byte(8'h2A, 1'b1);       // early end on a literal
        send_byte(8'hC3, 1'b1);       // early end with the count left waiting
        send_byte(8'hAA, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h99, 1'b1);       // early end on an empty run
        wait_drained();

        // one long row, single-row image
        send_gap_max = 0;
        recv_gap_max = 0;
        configure(262140, 262140, 1);
        send_random(40);
        wait_drained();

        // one-byte rows; the first writing run closes the long row
        send_gap_max = 10;
        recv_gap_max = 0;
        configure(1, 262140, 65536);
        send_random(40);
        wait_drained();

        send_gap_max = 0;
        recv_gap_max = 10;
        rows = board.row_now() + $urandom_range(100, 60000);
        if (rows > 65536)
            rows = 65536;
        configure($urandom_range(2, 16), $urandom_range(1, 20), rows);
        send_random(40);
        wait_drained();

        // every row overflows after its first byte
        send_gap_max = 10;
        recv_gap_max = 10;
        configure(4, 1, 65536);
        send_random(30);
        wait_drained();

        // fill the block while the receiver holds off, then pause and resume
        send_gap_max = 0;
        configure($urandom_range(2, 40), $urandom_range(2, 60), 65536);
        hold_output = 1'b1;
        send_random(30);
        wait_drained();
        send_gap_max = 10;
        send_random(30);
        if (board.run_armed)
            send_byte(8'h01, 1'b0);
        wait_drained();

        // two rows left: the first ends by overflow, the second by length
        rows = board.row_now() + 2;
        configure(3, 2, rows);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        wait_drained();
        configure(2, 10, rows);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h5A, 1'b0);
        // image finished: these are dropped without a word
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h77, 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        board.close_out();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pcx_pkg.sv
rtl/core/pcx_step_unit.sv
rtl/core/pcx_rle_scanline_decoder.sv
tb/pcx_rle_scanline_decoder_test.sv
